### hw/rtl/isort_pkg.sv
package isort_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int VALUE_W       = 32;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} dp_cmd_t;

	typedef struct packed {
		logic last_one;
	} dp_status_t;

endpackage

### hw/rtl/isort_ctrl.sv
module isort_ctrl
	import isort_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       last,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       busy,
	output logic       result_strobe
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		busy          = 1'b0;
		result_strobe = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				cmd.insert = start;
				if (start && last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				busy          = 1'b1;
				result_strobe = 1'b1;
				cmd.shift     = 1'b1;
				if (status.last_one) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

### hw/rtl/isort_dp.sv
module isort_dp
	import isort_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   cmd,
	input  logic signed [VALUE_W-1:0] value,
	output dp_status_t                status,
	output logic signed [VALUE_W-1:0] sorted_value,
	output logic                      run_end,
	output logic                      overflow
);

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	logic signed [VALUE_W-1:0] cell_q [MAX_ITEMS];
	logic        [CNT_W-1:0]   count_q;
	logic                      overflow_q;
	logic        [MAX_ITEMS-1:0] gt;
	logic                      full;

	assign full = (count_q == CNT_W'(MAX_ITEMS));

	// occupied cells holding a larger value move up to make room
	always_comb begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			gt[i] = (CNT_W'(i) < count_q) && (cell_q[i] > value);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			if (cmd.insert && !full) begin
				if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
					cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
				end else if (gt[i] || CNT_W'(i) == count_q) begin
					cell_q[i] <= value;
				end
			end else if (cmd.shift && i < MAX_ITEMS - 1) begin
				cell_q[i] <= cell_q[(i < MAX_ITEMS - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.insert) begin
			if (full) begin
				overflow_q <= 1'b1;
			end else begin
				count_q <= count_q + CNT_W'(1);
			end
		end else if (cmd.shift) begin
			count_q <= count_q - CNT_W'(1);
			if (count_q == CNT_W'(1)) begin
				overflow_q <= 1'b0;
			end
		end
	end

	assign status.last_one = (count_q == CNT_W'(1));
	assign sorted_value    = cell_q[0];
	assign run_end         = status.last_one;
	assign overflow        = overflow_q;

endmodule

### hw/rtl/integer_array_sorter.sv
// latency: the first sorted beat appears the cycle after the beat marked last is taken
// a run of held elements then streams out back to back, one per cycle
// loading takes one beat per cycle while busy is low; busy stays high while the run streams out
// the receiver cannot stall: each result is on the ports for exactly one cycle
// reset (arst_n low, asynchronous) empties the store and clears the overflow flag
module integer_array_sorter
	import isort_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      last,
	output logic                      result_strobe,
	output logic signed [VALUE_W-1:0] sorted_value,
	output logic                      run_end,
	output logic                      overflow
);

	dp_cmd_t    cmd;
	dp_status_t status;

	isort_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.last          (last),
		.status        (status),
		.cmd           (cmd),
		.busy          (busy),
		.result_strobe (result_strobe)
	);

	isort_dp #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (value),
		.status       (status),
		.sorted_value (sorted_value),
		.run_end      (run_end),
		.overflow     (overflow)
	);

	a_emit_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last |=> result_strobe)
		else $error("run did not start after last beat");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !run_end |=> result_strobe)
		else $error("run broke off before its end");

	a_idle_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && run_end |=> !busy)
		else $error("still busy after run end");

	a_no_insert_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.insert)
		else $error("insert while emitting");

endmodule

### tb/sv/tb_integer_array_sorter.sv
module tb_integer_array_sorter;
	import isort_pkg::*;

	localparam int CLK_HALF = 4;
	localparam int CLK_PERIOD = 2 * CLK_HALF;
	localparam int TOTAL_ITEMS = 110;
	localparam int OVERFLOW_LEN = MAX_ITEMS_DEF + 2;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
		int                        gap_pct;
		bit                        drain;
	} element_beat_t;

	typedef struct {
		logic signed [VALUE_W-1:0] sorted_value;
		logic                      run_end;
		logic                      overflow;
	} sorted_beat_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic signed [VALUE_W-1:0] value = '0;
	logic                      last = 1'b0;
	logic                      busy;
	logic                      result_strobe;
	logic signed [VALUE_W-1:0] sorted_value;
	logic                      run_end;
	logic                      overflow;

	element_beat_t pending_elements[$];
	sorted_beat_t  expected_sorted[$];

	logic signed [VALUE_W-1:0] held_sorted[MAX_ITEMS_DEF];
	int                        held_count = 0;
	bit                        dropped_seen = 1'b0;
	bit                        took = 1'b0;
	int                        mismatches = 0;

	integer_array_sorter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.last         (last),
		.result_strobe(result_strobe),
		.sorted_value (sorted_value),
		.run_end      (run_end),
		.overflow     (overflow)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// insert after equal elements; a last beat flushes the held set in order
	task automatic load_element(input logic signed [VALUE_W-1:0] v, input logic is_last);
		int pos;
		sorted_beat_t beat;
		if (held_count >= MAX_ITEMS_DEF) begin
			dropped_seen = 1'b1;
		end else begin
			pos = held_count;
			while (pos > 0 && held_sorted[pos-1] > v) begin
				held_sorted[pos] = held_sorted[pos-1];
				pos--;
			end
			held_sorted[pos] = v;
			held_count++;
		end
		if (is_last) begin
			for (int k = 0; k < held_count; k++) begin
				beat.sorted_value = held_sorted[k];
				beat.run_end = (k == held_count - 1);
				beat.overflow = dropped_seen;
				expected_sorted = {expected_sorted, beat};
			end
			held_count = 0;
			dropped_seen = 1'b0;
		end
	endtask

	task automatic add_element(input logic signed [VALUE_W-1:0] v, input logic is_last,
			input int gap, input bit drain);
		element_beat_t e;
		e.value = v;
		e.last = is_last;
		e.gap_pct = gap;
		e.drain = drain;
		pending_elements = {pending_elements, e};
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		int mode;
		mode = $urandom_range(99);
		if (mode < 20)
			return $signed(VALUE_W'($urandom_range(8))) - 4;
		else if (mode < 30)
			return $urandom_range(1) ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
		else
			return $urandom();
	endfunction

	task automatic add_random_array(input int len, input int gap, input bit drain);
		for (int i = 0; i < len; i++)
			add_element(pick_value(), i == len - 1, gap, drain && i == 0);
	endtask

	// fill the pending queue: directed arrays, then random runs, some with idle gaps
	initial begin
		int pcts[4];
		int random_count;
		int runs;
		int len;
		pcts = '{0, 73, 0, 36};

		add_element({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0, 0, 1'b0);
		add_element({1'b1, {(VALUE_W-1){1'b0}}}, 1'b0, 0, 1'b0);
		add_element(0, 1'b0, 0, 1'b0);
		add_element(-1, 1'b0, 0, 1'b0);
		add_element(1, 1'b0, 0, 1'b0);
		add_element({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0, 0, 1'b0);
		add_element({1'b1, {(VALUE_W-1){1'b0}}}, 1'b0, 0, 1'b0);
		add_element(-1, 1'b1, 0, 1'b0);
		// single element run
		add_element(5, 1'b1, 0, 1'b0);
		// duplicates must keep arrival order among equals
		add_element(3, 1'b0, 0, 1'b0);
		add_element(3, 1'b0, 0, 1'b0);
		add_element(-7, 1'b0, 0, 1'b0);
		add_element(3, 1'b0, 0, 1'b0);
		add_element(-7, 1'b0, 0, 1'b0);
		add_element(0, 1'b1, 0, 1'b0);
		// descending input
		add_element(4, 1'b0, 0, 1'b0);
		add_element(3, 1'b0, 0, 1'b0);
		add_element(2, 1'b0, 0, 1'b0);
		add_element(-2, 1'b1, 0, 1'b0);

		// full store: a non-last and the last beat both dropped
		add_random_array(OVERFLOW_LEN, 0, 1'b1);
		random_count = pending_elements.size();
		runs = 0;
		while (random_count < TOTAL_ITEMS) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			add_random_array(len, pcts[runs % 4], runs % 2 == 0);
			random_count += len;
			runs++;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do @(posedge clk); while (pending_elements.size() != 0 || start);
		while (expected_sorted.size() != 0) @(posedge clk);
		repeat (MAX_ITEMS_DEF + 8) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * 200000);
		$display("FAILED: results differ");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			took <= 1'b0;
		else
			took <= start && !busy;
	end

	// driver: a beat stays up until taken; drain marks hold off until results are in
	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (pending_elements.size() != 0
					&& !(pending_elements[0].drain && expected_sorted.size() != 0)
					&& $urandom_range(99) >= pending_elements[0].gap_pct) begin
				start <= 1'b1;
				value <= pending_elements[0].value;
				last <= pending_elements[0].last;
				void'(pending_elements.pop_front());
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		sorted_beat_t want;
		if (arst_n) begin
			if (start && !busy)
				load_element(value, last);
			if (result_strobe) begin
				if (expected_sorted.size() == 0) begin
					$error("unexpected result beat: sorted_value %0d", sorted_value);
					mismatches++;
				end else begin
					want = expected_sorted.pop_front();
					if (sorted_value !== want.sorted_value) begin
						$error("sorted_value: expected %0d, got %0d", want.sorted_value,
							sorted_value);
						mismatches++;
					end
					if (run_end !== want.run_end) begin
						$error("run_end: expected %0b, got %0b", want.run_end, run_end);
						mismatches++;
					end
					if (overflow !== want.overflow) begin
						$error("overflow: expected %0b, got %0b", want.overflow, overflow);
						mismatches++;
					end
				end
			end
		end
	end

endmodule

### files.f
hw/rtl/isort_pkg.sv
hw/rtl/isort_ctrl.sv
hw/rtl/isort_dp.sv
hw/rtl/integer_array_sorter.sv
tb/sv/tb_integer_array_sorter.sv
